@@ hw/rtl/gasp_pkg.sv @@
// Shared types, codes and step tables of the grid path search block.
`timescale 1ns / 1ps
`default_nettype none

package gasp_pkg;

	// Result kinds
	localparam logic [1:0] KIND_CELL = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	// Input word modes
	localparam logic MODE_OBSTACLE = 1'b0;
	localparam logic MODE_SEARCH   = 1'b1;

	// Register indexes and width of the register data
	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;
	localparam int   CFG_BITS       = 9;
	localparam logic [CFG_BITS-1:0] MAP_RESET = 9'd256;

	// Neighbour steps: four straight ones, then four diagonals
	localparam logic signed [1:0] STEP_DX [8] = '{2'sb00, 2'sb00, 2'sb11, 2'sb01,
		2'sb11, 2'sb11, 2'sb01, 2'sb01};
	localparam logic signed [1:0] STEP_DY [8] = '{2'sb11, 2'sb01, 2'sb00, 2'sb00,
		2'sb11, 2'sb01, 2'sb11, 2'sb01};

	typedef enum logic [2:0] {
		SCAN_MIN,
		SCAN_OBS,
		SCAN_CLOSED,
		SCAN_DUP,
		SCAN_SHIFT
	} scan_kind_t;

	typedef struct packed {
		logic       obs_wr;
		logic       start;
		logic       scan_init;
		scan_kind_t scan_kind;
		logic       scan_run;
		logic       close;
		logic       dir_first;
		logic       dir_next;
		logic       sq1;
		logic       sq2;
		logic       push;
		logic       shift_end;
		logic       trace_start;
		logic       trace_step;
		logic       out_cell;
		logic       out_ok;
		logic       out_fail;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic open_empty;
		logic over_limit;
		logic at_goal;
		logic child_in;
		logic blocked;
		logic closed_hit;
		logic dup;
		logic dir_last;
		logic trace_more;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/gasp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gasp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/gasp_ctrl.sv @@
// Sequencer of the path search: steps the datapath through each expansion.
`timescale 1ns / 1ps
`default_nettype none

module gasp_ctrl
	import gasp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_CHK    = 14'b00000000000010,
		S_SEL    = 14'b00000000000100,
		S_CLOSE  = 14'b00000000001000,
		S_DIR    = 14'b00000000010000,
		S_OBS    = 14'b00000000100000,
		S_CLSD   = 14'b00000001000000,
		S_SQ     = 14'b00000010000000,
		S_DUP    = 14'b00000100000000,
		S_NEXT   = 14'b00001000000000,
		S_SHIFT  = 14'b00010000000000,
		S_TR_RD  = 14'b00100000000000,
		S_TR_CHK = 14'b01000000000000,
		S_FAIL   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.scan_kind = SCAN_MIN;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_SEARCH) begin
						cmd.start = 1'b1;
						state_d = S_CHK;
					end else begin
						cmd.obs_wr = 1'b1;
					end
				end
			end
			S_CHK: begin
				if (sts.open_empty) begin
					state_d = S_FAIL;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_kind = SCAN_MIN;
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				if (sts.over_limit) begin
					state_d = S_FAIL;
				end else if (sts.at_goal) begin
					cmd.trace_start = 1'b1;
					state_d = S_TR_RD;
				end else begin
					cmd.dir_first = 1'b1;
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				if (!sts.child_in) begin
					state_d = S_NEXT;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_kind = SCAN_OBS;
					state_d = S_OBS;
				end
			end
			S_OBS: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					if (sts.blocked) begin
						state_d = S_NEXT;
					end else begin
						cmd.scan_init = 1'b1;
						cmd.scan_kind = SCAN_CLOSED;
						state_d = S_CLSD;
					end
				end
			end
			S_CLSD: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					if (sts.closed_hit) begin
						state_d = S_NEXT;
					end else begin
						cmd.sq1 = 1'b1;
						state_d = S_SQ;
					end
				end
			end
			S_SQ: begin
				cmd.sq2 = 1'b1;
				cmd.scan_init = 1'b1;
				cmd.scan_kind = SCAN_DUP;
				state_d = S_DUP;
			end
			S_DUP: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					cmd.push = !sts.dup;
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (sts.dir_last) begin
					cmd.scan_init = 1'b1;
					cmd.scan_kind = SCAN_SHIFT;
					state_d = S_SHIFT;
				end else begin
					cmd.dir_next = 1'b1;
					state_d = S_DIR;
				end
			end
			S_SHIFT: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					cmd.shift_end = 1'b1;
					state_d = S_CHK;
				end
			end
			S_TR_RD: begin
				state_d = S_TR_CHK;
			end
			S_TR_CHK: begin
				if (sts.out_free) begin
					if (sts.trace_more) begin
						cmd.out_cell = 1'b1;
						cmd.trace_step = 1'b1;
						state_d = S_TR_RD;
					end else begin
						cmd.out_ok = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_FAIL: begin
				if (sts.out_free) begin
					cmd.out_fail = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/gasp_dpath.sv @@
// Datapath of the path search: stores, scan unit, distance math and result register.
`timescale 1ns / 1ps
`default_nettype none

module gasp_dpath
	import gasp_pkg::*;
#(
	parameter int NODE_LIMIT    = 64,
	parameter int MAX_OBSTACLES = 16,
	parameter int COORD_BITS    = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                cfg_en,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic [3:0]          obstacle_slot,
	input  logic                obstacle_active,
	input  logic [7:0]          obstacle_x,
	input  logic [7:0]          obstacle_y,
	input  logic [8:0]          obstacle_w,
	input  logic [8:0]          obstacle_h,
	input  logic [7:0]          start_x,
	input  logic [7:0]          start_y,
	input  logic [7:0]          goal_x,
	input  logic [7:0]          goal_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          cell_x,
	output logic [7:0]          cell_y,
	output logic                run_end
);

	localparam int XW         = ((COORD_BITS > 9) ? COORD_BITS : 9) + 2;
	localparam int NODE_CAP   = 8 * NODE_LIMIT + 1;
	localparam int OPEN_CAP   = NODE_LIMIT + 8;
	localparam int CLOSED_CAP = NODE_LIMIT + 1;
	localparam int NW         = $clog2(NODE_CAP);
	localparam int NCW        = $clog2(NODE_CAP + 1);
	localparam int OAW        = $clog2(OPEN_CAP);
	localparam int OCW        = $clog2(OPEN_CAP + 1);
	localparam int CAW        = $clog2(CLOSED_CAP);
	localparam int CCW        = $clog2(CLOSED_CAP + 1);
	localparam int OSW        = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int SCW        = $clog2(((OPEN_CAP > MAX_OBSTACLES) ? OPEN_CAP : MAX_OBSTACLES) + 1);
	localparam int GW         = $clog2(NODE_LIMIT + 2);
	localparam int FW         = 2 * XW + 1;
	localparam int KW         = $clog2(NODE_LIMIT);
	localparam logic signed [XW-1:0] LIM = XW'(1 << COORD_BITS);

	typedef struct packed {
		logic                 has_parent;
		logic [NW-1:0]        parent;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
	} node_ent_t;

	typedef struct packed {
		logic [NW-1:0]        idx;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [GW-1:0]        g;
		logic [FW-1:0]        f;
	} open_ent_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
	} closed_ent_t;

	function automatic logic rect_hit(input logic act, input logic [7:0] ox, input logic [7:0] oy,
		input logic [8:0] ow, input logic [8:0] oh,
		input logic signed [XW-1:0] px, input logic signed [XW-1:0] py);
		logic signed [XW-1:0] x0, y0, x1, y1;
		x0 = signed'(XW'(ox));
		y0 = signed'(XW'(oy));
		x1 = x0 + signed'(XW'(ow));
		y1 = y0 + signed'(XW'(oh));
		return act && (px >= x0) && (px < x1) && (py >= y0) && (py < y1);
	endfunction

	// Registers
	logic [CFG_BITS-1:0] map_w_q, map_h_q;
	logic                obs_act_q [MAX_OBSTACLES];
	logic [7:0]          obs_x_q [MAX_OBSTACLES];
	logic [7:0]          obs_y_q [MAX_OBSTACLES];
	logic [8:0]          obs_w_q [MAX_OBSTACLES];
	logic [8:0]          obs_h_q [MAX_OBSTACLES];
	logic [7:0]          goal_x_q, goal_y_q;
	logic [OCW-1:0]      open_n_q;
	logic [CCW-1:0]      closed_n_q;
	logic [NCW-1:0]      node_n_q;
	scan_kind_t          scan_kind_q;
	logic [SCW-1:0]      cnt_q, pidx_q, best_pos_q;
	logic                pend_q;
	logic                blocked_q, closed_hit_q, dup_q;
	logic [NW-1:0]       cur_idx_q;
	logic signed [XW-1:0] cur_x_q, cur_y_q;
	logic [GW-1:0]       cur_g_q;
	logic [FW-1:0]       best_f_q, child_f_q;
	logic [2:0]          dir_q;
	logic signed [2*XW-1:0] sqx_s1, sqy_s1;
	logic [NW-1:0]       trace_n_q;
	logic [KW-1:0]       trace_k_q;
	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic [7:0]          cell_x_q, cell_y_q;
	logic                run_end_q;

	// Combinational
	logic signed [XW-1:0] dx_e, dy_e, nx, ny, w_e, h_e, wlim, hlim, gx_e, gy_e, dgx, dgy;
	logic [GW-1:0]        child_g;
	logic                 diag;
	logic [SCW-1:0]       lim;
	logic [OSW-1:0]       obs_i;
	logic                 obs_hit;
	node_ent_t            node_wd, node_rd;
	open_ent_t            open_wd, open_rd;
	closed_ent_t          closed_wd, closed_rd;
	logic                 node_we, open_we, shift_wr;
	logic [NW-1:0]        node_wa;
	logic [OAW-1:0]       open_wa;
	logic                 scan_step, pend_use;

	assign dx_e    = XW'(STEP_DX[dir_q]);
	assign dy_e    = XW'(STEP_DY[dir_q]);
	assign nx      = cur_x_q + dx_e;
	assign ny      = cur_y_q + dy_e;
	assign diag    = dir_q[2];
	assign child_g = cur_g_q + GW'(1);
	assign w_e     = signed'(XW'(map_w_q));
	assign h_e     = signed'(XW'(map_h_q));
	assign wlim    = (w_e > LIM) ? LIM : w_e;
	assign hlim    = (h_e > LIM) ? LIM : h_e;
	assign gx_e    = signed'(XW'(goal_x_q));
	assign gy_e    = signed'(XW'(goal_y_q));
	assign dgx     = nx - gx_e;
	assign dgy     = ny - gy_e;

	always_comb begin
		unique case (scan_kind_q)
			SCAN_OBS:    lim = SCW'(MAX_OBSTACLES);
			SCAN_CLOSED: lim = SCW'(closed_n_q);
			SCAN_MIN, SCAN_DUP, SCAN_SHIFT: lim = SCW'(open_n_q);
			default:     lim = '0;
		endcase
	end

	assign scan_step = cmd.scan_run && (cnt_q < lim);
	assign pend_use  = cmd.scan_run && pend_q;
	assign obs_i     = cnt_q[OSW-1:0];

	// Point itself, then the two corner cells that a diagonal step passes
	always_comb begin
		obs_hit = rect_hit(obs_act_q[obs_i], obs_x_q[obs_i], obs_y_q[obs_i],
			obs_w_q[obs_i], obs_h_q[obs_i], nx, ny);
		if (diag) begin
			obs_hit = obs_hit
				| rect_hit(obs_act_q[obs_i], obs_x_q[obs_i], obs_y_q[obs_i],
					obs_w_q[obs_i], obs_h_q[obs_i], nx, cur_y_q)
				| rect_hit(obs_act_q[obs_i], obs_x_q[obs_i], obs_y_q[obs_i],
					obs_w_q[obs_i], obs_h_q[obs_i], cur_x_q, ny);
		end
	end

	// Store write ports
	assign shift_wr = pend_use && (scan_kind_q == SCAN_SHIFT);
	assign node_we  = cmd.start | cmd.push;
	assign open_we  = cmd.start | cmd.push | shift_wr;

	always_comb begin
		node_wd = '0;
		open_wd = open_rd;
		node_wa = node_n_q[NW-1:0];
		open_wa = OAW'(pidx_q - SCW'(1));
		if (cmd.start) begin
			node_wd.x = signed'(XW'(start_x));
			node_wd.y = signed'(XW'(start_y));
			node_wa   = '0;
			open_wd   = '0;
			open_wd.x = signed'(XW'(start_x));
			open_wd.y = signed'(XW'(start_y));
			open_wa   = '0;
		end else if (cmd.push) begin
			node_wd.has_parent = 1'b1;
			node_wd.parent     = cur_idx_q;
			node_wd.x          = nx;
			node_wd.y          = ny;
			open_wd.idx        = node_n_q[NW-1:0];
			open_wd.x          = nx;
			open_wd.y          = ny;
			open_wd.g          = child_g;
			open_wd.f          = child_f_q;
			open_wa            = open_n_q[OAW-1:0];
		end
	end

	assign closed_wd.x = cur_x_q;
	assign closed_wd.y = cur_y_q;

	gasp_ram #(.WIDTH($bits(node_ent_t)), .DEPTH(NODE_CAP)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_wa),
		.wdata (node_wd),
		.raddr (trace_n_q),
		.rdata (node_rd)
	);

	gasp_ram #(.WIDTH($bits(open_ent_t)), .DEPTH(OPEN_CAP)) u_open_ram (
		.clk   (clk),
		.we    (open_we),
		.waddr (open_wa),
		.wdata (open_wd),
		.raddr (cnt_q[OAW-1:0]),
		.rdata (open_rd)
	);

	gasp_ram #(.WIDTH($bits(closed_ent_t)), .DEPTH(CLOSED_CAP)) u_closed_ram (
		.clk   (clk),
		.we    (cmd.close),
		.waddr (closed_n_q[CAW-1:0]),
		.wdata (closed_wd),
		.raddr (cnt_q[CAW-1:0]),
		.rdata (closed_rd)
	);

	// Configuration, obstacle valid bits, counts, scan control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= MAP_RESET;
			map_h_q <= MAP_RESET;
			for (int k = 0; k < MAX_OBSTACLES; k++) begin
				obs_act_q[k] <= 1'b0;
			end
			open_n_q    <= '0;
			closed_n_q  <= '0;
			node_n_q    <= '0;
			scan_kind_q <= SCAN_MIN;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_en) begin
				unique case (cfg_index)
					REG_MAP_WIDTH:  map_w_q <= cfg_data;
					REG_MAP_HEIGHT: map_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.obs_wr) begin
				for (int k = 0; k < MAX_OBSTACLES; k++) begin
					if (9'(obstacle_slot) == 9'(k)) begin
						obs_act_q[k] <= obstacle_active;
					end
				end
			end
			if (cmd.start) begin
				open_n_q   <= OCW'(1);
				closed_n_q <= '0;
				node_n_q   <= NCW'(1);
			end
			if (cmd.close) begin
				closed_n_q <= closed_n_q + CCW'(1);
			end
			if (cmd.push) begin
				open_n_q <= open_n_q + OCW'(1);
				node_n_q <= node_n_q + NCW'(1);
			end
			if (cmd.shift_end) begin
				open_n_q <= open_n_q - OCW'(1);
			end
			if (cmd.scan_init) begin
				scan_kind_q <= cmd.scan_kind;
				pend_q      <= 1'b0;
				cnt_q       <= (cmd.scan_kind == SCAN_SHIFT) ? best_pos_q + SCW'(1) : '0;
			end else if (cmd.scan_run) begin
				pend_q <= scan_step && (scan_kind_q != SCAN_OBS);
				if (scan_step) begin
					cnt_q <= cnt_q + SCW'(1);
				end
			end
			if (cmd.out_cell || cmd.out_ok || cmd.out_fail) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.obs_wr) begin
			for (int k = 0; k < MAX_OBSTACLES; k++) begin
				if (9'(obstacle_slot) == 9'(k)) begin
					obs_x_q[k] <= obstacle_x;
					obs_y_q[k] <= obstacle_y;
					obs_w_q[k] <= obstacle_w;
					obs_h_q[k] <= obstacle_h;
				end
			end
		end
		if (cmd.start) begin
			goal_x_q <= goal_x;
			goal_y_q <= goal_y;
		end
		if (cmd.scan_init) begin
			blocked_q    <= 1'b0;
			closed_hit_q <= 1'b0;
			dup_q        <= 1'b0;
		end else begin
			if (scan_step) begin
				pidx_q <= cnt_q;
				if (scan_kind_q == SCAN_OBS && obs_hit) begin
					blocked_q <= 1'b1;
				end
			end
			if (pend_use) begin
				case (scan_kind_q)
					SCAN_MIN: begin
						if (pidx_q == '0 || open_rd.f < best_f_q) begin
							best_pos_q <= pidx_q;
							best_f_q   <= open_rd.f;
							cur_idx_q  <= open_rd.idx;
							cur_x_q    <= open_rd.x;
							cur_y_q    <= open_rd.y;
							cur_g_q    <= open_rd.g;
						end
					end
					SCAN_CLOSED: begin
						if (closed_rd.x == nx && closed_rd.y == ny) begin
							closed_hit_q <= 1'b1;
						end
					end
					SCAN_DUP: begin
						if (open_rd.x == nx && open_rd.y == ny && child_g >= open_rd.g) begin
							dup_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
		if (cmd.dir_first) begin
			dir_q <= 3'd0;
		end else if (cmd.dir_next) begin
			dir_q <= dir_q + 3'd1;
		end
		if (cmd.sq1) begin
			sqx_s1 <= (2*XW)'(dgx) * (2*XW)'(dgx);
			sqy_s1 <= (2*XW)'(dgy) * (2*XW)'(dgy);
		end
		if (cmd.sq2) begin
			child_f_q <= FW'(child_g) + FW'($unsigned(sqx_s1)) + FW'($unsigned(sqy_s1));
		end
		if (cmd.trace_start) begin
			trace_n_q <= cur_idx_q;
			trace_k_q <= '0;
		end else if (cmd.trace_step) begin
			trace_n_q <= node_rd.parent;
			trace_k_q <= trace_k_q + KW'(1);
		end
		if (cmd.out_cell) begin
			kind_q    <= KIND_CELL;
			cell_x_q  <= node_rd.x[7:0];
			cell_y_q  <= node_rd.y[7:0];
			run_end_q <= 1'b0;
		end else if (cmd.out_ok || cmd.out_fail) begin
			kind_q    <= cmd.out_ok ? KIND_OK : KIND_FAIL;
			cell_x_q  <= '0;
			cell_y_q  <= '0;
			run_end_q <= 1'b1;
		end
	end

	always_comb begin
		sts.scan_done  = (cnt_q >= lim) && !pend_q;
		sts.open_empty = (open_n_q == '0);
		sts.over_limit = ((CCW+1)'(closed_n_q) + (CCW+1)'(1) > (CCW+1)'(NODE_LIMIT))
			|| (open_n_q > OCW'(NODE_LIMIT));
		sts.at_goal    = (cur_x_q == gx_e) && (cur_y_q == gy_e);
		sts.child_in   = !nx[XW-1] && (nx < wlim) && !ny[XW-1] && (ny < hlim);
		sts.blocked    = blocked_q;
		sts.closed_hit = closed_hit_q;
		sts.dup        = dup_q;
		sts.dir_last   = (dir_q == 3'd7);
		sts.trace_more = node_rd.has_parent && (trace_k_q < KW'(NODE_LIMIT - 1));
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign cell_x    = cell_x_q;
	assign cell_y    = cell_y_q;
	assign run_end   = run_end_q;

endmodule

`default_nettype wire

@@ hw/rtl/grid_astar_path_search.sv @@
// Top level of the grid path search block: sequencer plus datapath.
//
// Input channel (in_valid/in_ready): one word per request. mode 0 writes one
// obstacle rectangle slot and is taken with no result, leaving in_ready high.
// mode 1 runs an 8-connected A* search from start to goal; in_ready stays low
// until the last result word of that search is loaded into the output register.
// Output channel (out_valid/out_ready): a successful search gives the path
// cells from goal back toward start (start excluded), then a kind 1 word with
// run_end set; a failed search gives one kind 2 word with run_end set.
// Each expansion scans the open list to pick the least f entry, then for each
// neighbour on the map runs serial scans of the obstacle slots, the closed list
// and the open list, stopping at the first scan that rejects it, then shifts the
// open list to close the gap. A path cell is loaded as the previous word is taken.
// The open, closed and node stores each read one entry per cycle.
// Reset clears the counts, the active bits of all obstacle slots and the output
// valid flag, and sets both map size registers to 256. When the receiver stalls,
// hold the result word and pause the path walk; a new request is taken as soon as
// the final word of the run sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module grid_astar_path_search
	import gasp_pkg::*;
#(
	parameter int NODE_LIMIT    = 64,
	parameter int MAX_OBSTACLES = 16,
	parameter int COORD_BITS    = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_en,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [3:0]          obstacle_slot,
	input  logic                obstacle_active,
	input  logic [7:0]          obstacle_x,
	input  logic [7:0]          obstacle_y,
	input  logic [8:0]          obstacle_w,
	input  logic [8:0]          obstacle_h,
	input  logic [7:0]          start_x,
	input  logic [7:0]          start_y,
	input  logic [7:0]          goal_x,
	input  logic [7:0]          goal_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          cell_x,
	output logic [7:0]          cell_y,
	output logic                run_end
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer: one state per scan or math step of an expansion, plus idle, path walk and fail states
	gasp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: stores, shared scan counter, distance squares, output word
	gasp_dpath #(
		.NODE_LIMIT    (NODE_LIMIT),
		.MAX_OBSTACLES (MAX_OBSTACLES),
		.COORD_BITS    (COORD_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_en          (cfg_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.obstacle_slot   (obstacle_slot),
		.obstacle_active (obstacle_active),
		.obstacle_x      (obstacle_x),
		.obstacle_y      (obstacle_y),
		.obstacle_w      (obstacle_w),
		.obstacle_h      (obstacle_h),
		.start_x         (start_x),
		.start_y         (start_y),
		.goal_x          (goal_x),
		.goal_y          (goal_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.cell_x          (cell_x),
		.cell_y          (cell_y),
		.run_end         (run_end)
	);

endmodule

`default_nettype wire

@@ hw/rtl/gasp_checker.sv @@
// Port-level checks of the grid path search block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module gasp_checker
	import gasp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] cell_x,
	input logic [7:0] cell_y,
	input logic       run_end
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(cell_x)
			&& $stable(cell_y) && $stable(run_end))
		else $error("stalled result word changed");

	// run_end marks exactly the status words
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_end == (kind != KIND_CELL)))
		else $error("run_end does not match kind");

	// Status words carry zero coordinates
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_OK || kind == KIND_FAIL) |-> cell_x == 8'd0 && cell_y == 8'd0)
		else $error("status word with nonzero cell");

	// A taken search request is followed by in_ready low
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_SEARCH |=> !in_ready)
		else $error("input open right after a search request");

endmodule

bind grid_astar_path_search gasp_checker u_gasp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.cell_x    (cell_x),
	.cell_y    (cell_y),
	.run_end   (run_end)
);

`default_nettype wire

@@ tb/tb_grid_astar_path_search.sv @@
// Self-checking testbench of the grid path search block: directed table, then random phases.
`timescale 1ns / 1ps

module tb_grid_astar_path_search;
	import gasp_pkg::*;

	localparam int NODE_LIMIT    = 64;
	localparam int MAX_OBSTACLES = 16;
	localparam int NODE_CAP      = 8 * NODE_LIMIT + 1;
	localparam int OPEN_CAP      = NODE_LIMIT + 8;
	localparam int CLOSED_CAP    = NODE_LIMIT + 1;
	localparam int GRID_LIM      = 256;
	// Covers a search that runs into the node limit with no word moving.
	localparam int IDLE_LIMIT    = 400000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int HOLD_CYCLES   = 3000;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] x;
		logic [7:0] y;
		logic       last;
	} result_word_t;

	typedef enum logic {ROW_CFG, ROW_WORD} row_op_t;

	typedef struct {
		row_op_t    op;
		logic       md;
		logic [3:0] slot;
		logic       act;
		logic [7:0] ox, oy;
		logic [8:0] ow, oh;   // map width and height on configuration rows
		logic [7:0] sx, sy, gx, gy;
		logic       typed;    // expected status typed in, no path cells
		logic [1:0] tkind;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_en;
	logic                cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                mode;
	logic [3:0]          obstacle_slot;
	logic                obstacle_active;
	logic [7:0]          obstacle_x, obstacle_y;
	logic [8:0]          obstacle_w, obstacle_h;
	logic [7:0]          start_x, start_y, goal_x, goal_y;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          kind;
	logic [7:0]          cell_x, cell_y;
	logic                run_end;

	grid_astar_path_search DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .obstacle_slot(obstacle_slot), .obstacle_active(obstacle_active),
		.obstacle_x(obstacle_x), .obstacle_y(obstacle_y),
		.obstacle_w(obstacle_w), .obstacle_h(obstacle_h),
		.start_x(start_x), .start_y(start_y), .goal_x(goal_x), .goal_y(goal_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .cell_x(cell_x), .cell_y(cell_y), .run_end(run_end)
	);

	// Mirror of the block state: map size and obstacle rectangles
	int map_w, map_h;
	logic ob_act [MAX_OBSTACLES];
	int   ob_x [MAX_OBSTACLES], ob_y [MAX_OBSTACLES];
	int   ob_w [MAX_OBSTACLES], ob_h [MAX_OBSTACLES];

	// Scratch stores of the search mirror
	int nd_x [NODE_CAP], nd_y [NODE_CAP], nd_g [NODE_CAP], nd_f [NODE_CAP], nd_par [NODE_CAP];
	int open_ids [OPEN_CAP];
	int closed_ids [CLOSED_CAP];

	result_word_t expected_words [$];
	int  mismatches;
	int  stall_pct, idle_pct;
	logic hold_off;
	int  idle_cycles;

	// Clock and the one reset at start
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void push_word(logic [1:0] k, int x, int y, logic last);
		result_word_t w;
		w.kind = k;
		w.x = x[7:0];
		w.y = y[7:0];
		w.last = last;
		expected_words.push_back(w);
	endfunction

	function automatic bit cell_blocked(int x, int y);
		for (int i = 0; i < MAX_OBSTACLES; i++)
			if (ob_act[i] && x >= ob_x[i] && x < ob_x[i] + ob_w[i] &&
				y >= ob_y[i] && y < ob_y[i] + ob_h[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit on_map(int x, int y);
		int w, h;
		w = (map_w > GRID_LIM) ? GRID_LIM : map_w;
		h = (map_h > GRID_LIM) ? GRID_LIM : map_h;
		return x >= 0 && x < w && y >= 0 && y < h;
	endfunction

	// A* mirror: expand least f (first in list order), push path or status words
	function automatic void predict_search(int sx, int sy, int gx, int gy);
		int open_n, closed_n, node_n, best, cur, nx, ny, g, k, n;
		bit skip;
		open_n = 0;
		closed_n = 0;
		nd_x[0] = sx; nd_y[0] = sy; nd_g[0] = 0; nd_f[0] = 0; nd_par[0] = -1;
		node_n = 1;
		open_ids[open_n++] = 0;
		while (open_n > 0) begin
			best = 0;
			for (int i = 1; i < open_n; i++)
				if (nd_f[open_ids[i]] < nd_f[open_ids[best]]) best = i;
			cur = open_ids[best];
			if (closed_n >= CLOSED_CAP) begin
				push_word(KIND_FAIL, 0, 0, 1'b1);
				return;
			end
			closed_ids[closed_n++] = cur;
			if (closed_n > NODE_LIMIT || open_n > NODE_LIMIT) begin
				push_word(KIND_FAIL, 0, 0, 1'b1);
				return;
			end
			if (nd_x[cur] == gx && nd_y[cur] == gy) begin
				// walk back from goal, start left out
				k = 0;
				n = cur;
				while (n >= 0 && nd_par[n] >= 0 && k < NODE_LIMIT - 1) begin
					push_word(KIND_CELL, nd_x[n], nd_y[n], 1'b0);
					k++;
					n = nd_par[n];
				end
				push_word(KIND_OK, 0, 0, 1'b1);
				return;
			end
			for (int d = 0; d < 8; d++) begin
				nx = nd_x[cur] + int'(STEP_DX[d]);
				ny = nd_y[cur] + int'(STEP_DY[d]);
				if (!on_map(nx, ny) || cell_blocked(nx, ny)) continue;
				// refuse a diagonal that cuts a blocked corner
				if (d >= 4 && (cell_blocked(nx, nd_y[cur]) || cell_blocked(nd_x[cur], ny)))
					continue;
				skip = 1'b0;
				for (int j = 0; j < closed_n; j++)
					if (nd_x[closed_ids[j]] == nx && nd_y[closed_ids[j]] == ny) skip = 1'b1;
				if (skip) continue;
				g = nd_g[cur] + 1;
				for (int j = 0; j < open_n; j++)
					if (nd_x[open_ids[j]] == nx && nd_y[open_ids[j]] == ny &&
						g >= nd_g[open_ids[j]]) skip = 1'b1;
				if (skip || node_n >= NODE_CAP || open_n >= OPEN_CAP) continue;
				nd_x[node_n] = nx;
				nd_y[node_n] = ny;
				nd_g[node_n] = g;
				nd_f[node_n] = g + (nx - gx) * (nx - gx) + (ny - gy) * (ny - gy);
				nd_par[node_n] = cur;
				open_ids[open_n++] = node_n++;
			end
			// close the gap, keep order of the rest
			for (int i = best; i < open_n - 1; i++) open_ids[i] = open_ids[i + 1];
			open_n--;
		end
		push_word(KIND_FAIL, 0, 0, 1'b1);
	endfunction

	// Wait until every expected word is out, then let a mode 0 write settle
	task automatic drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_map(int w, int h);
		drain();
		cfg_en <= 1'b1;
		cfg_index <= REG_MAP_WIDTH;
		cfg_data <= w[CFG_BITS-1:0];
		@(posedge clk);
		cfg_index <= REG_MAP_HEIGHT;
		cfg_data <= h[CFG_BITS-1:0];
		@(posedge clk);
		cfg_en <= 1'b0;
		map_w = w;
		map_h = h;
	endtask

	// Offer one word after an optional idle gap, hold it until taken, then update the mirror
	task automatic send_word(stim_row_t r);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(1, 6)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.md;
		obstacle_slot <= r.slot;
		obstacle_active <= r.act;
		obstacle_x <= r.ox;
		obstacle_y <= r.oy;
		obstacle_w <= r.ow;
		obstacle_h <= r.oh;
		start_x <= r.sx;
		start_y <= r.sy;
		goal_x <= r.gx;
		goal_y <= r.gy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (r.md == MODE_OBSTACLE) begin
			ob_act[r.slot] = r.act;
			ob_x[r.slot] = r.ox;
			ob_y[r.slot] = r.oy;
			ob_w[r.slot] = r.ow;
			ob_h[r.slot] = r.oh;
		end else if (r.typed) begin
			push_word(r.tkind, 0, 0, 1'b1);
		end else begin
			predict_search(r.sx, r.sy, r.gx, r.gy);
		end
	endtask

	function automatic stim_row_t make_row(row_op_t op, int md, int slot, int act,
		int ox, int oy, int ow, int oh, int sx, int sy, int gx, int gy,
		logic typed, logic [1:0] tk);
		stim_row_t r;
		r.op = op; r.md = md[0]; r.slot = slot[3:0]; r.act = act[0];
		r.ox = ox[7:0]; r.oy = oy[7:0]; r.ow = ow[8:0]; r.oh = oh[8:0];
		r.sx = sx[7:0]; r.sy = sy[7:0]; r.gx = gx[7:0]; r.gy = gy[7:0];
		r.typed = typed; r.tkind = tk;
		return r;
	endfunction

	// Random word; far searches keep the goal within three cells of start per axis on the full map
	function automatic stim_row_t random_row(bit far);
		stim_row_t r;
		int span, d;
		r = make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, KIND_OK);
		if ($urandom_range(99) < 25) begin
			r.md = MODE_OBSTACLE;
			r.slot = 4'($urandom_range(15));
			if ($urandom_range(3) == 0) begin
				// full-range fields, kept inactive so big maps stay open
				r.act = 1'b0;
				{r.ox, r.oy} = 16'($urandom);
				r.ow = 9'($urandom_range(256));
				r.oh = 9'($urandom_range(256));
			end else begin
				r.act = 1'($urandom_range(1));
				r.ox = 8'($urandom_range(7));
				r.oy = 8'($urandom_range(7));
				r.ow = 9'($urandom_range(2));
				r.oh = 9'($urandom_range(2));
			end
			{r.sx, r.sy, r.gx, r.gy} = $urandom;
		end else if (far) begin
			r.sx = 8'($urandom_range(255));
			r.sy = 8'($urandom_range(255));
			d = int'(r.sx) + int'($urandom_range(6)) - 3;
			r.gx = 8'((d < 0) ? 0 : (d > 255) ? 255 : d);
			d = int'(r.sy) + int'($urandom_range(6)) - 3;
			r.gy = 8'((d < 0) ? 0 : (d > 255) ? 255 : d);
		end else begin
			// mostly inside the map, now and then one cell past its edge
			span = ($urandom_range(9) == 0) ? 0 : 1;
			r.sx = 8'($urandom_range(map_w - span));
			r.sy = 8'($urandom_range(map_h - span));
			r.gx = 8'($urandom_range(map_w - span));
			r.gy = 8'($urandom_range(map_h - span));
		end
		return r;
	endfunction

	task automatic run_phase(int n, int sidle, int rstall, int w, int h, bit far, bit press);
		write_map(w, h);
		idle_pct = sidle;
		stall_pct = rstall;
		if (press)
			fork
				begin
					// long receiver hold-off while searches keep being offered
					hold_off <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_off <= 1'b0;
				end
			join_none
		for (int i = 0; i < n; i++) send_word(random_row(far));
		in_valid <= 1'b0;
	endtask

	stim_row_t directed [$];

	initial begin
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = REG_MAP_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_OBSTACLE;
		obstacle_slot = '0;
		obstacle_active = 1'b0;
		obstacle_x = '0; obstacle_y = '0; obstacle_w = '0; obstacle_h = '0;
		start_x = '0; start_y = '0; goal_x = '0; goal_y = '0;
		hold_off = 1'b0;
		mismatches = 0;
		stall_pct = 0;
		idle_pct = 0;
		map_w = int'(MAP_RESET);
		map_h = int'(MAP_RESET);
		for (int i = 0; i < MAX_OBSTACLES; i++) begin
			ob_act[i] = 1'b0;
			ob_x[i] = 0; ob_y[i] = 0; ob_w[i] = 0; ob_h[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: start on goal at both corners, blocked corners,
		// empty rectangles, node limit, zero, one and oversized maps
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 1'b1, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			255, 255, 255, 255, 1'b1, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			0, 0, 3, 2, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_OBSTACLE, 0, 1, 1, 0, 1, 1,
			0, 0, 0, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_OBSTACLE, 15, 1, 0, 1, 1, 1,
			0, 0, 0, 0, 1'b0, KIND_OK));
		// walled in: both straight steps blocked and the diagonal cuts a corner
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			0, 0, 2, 2, 1'b1, KIND_FAIL));
		directed.push_back(make_row(ROW_WORD, MODE_OBSTACLE, 0, 0, 255, 255, 256, 256,
			255, 255, 255, 255, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			1, 0, 0, 2, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_OBSTACLE, 15, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_OBSTACLE, 3, 1, 200, 200, 0, 0,
			0, 0, 0, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			250, 250, 255, 255, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			0, 0, 255, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			1, 1, 2, 2, 1'b1, KIND_FAIL));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			5, 5, 5, 5, 1'b1, KIND_OK));
		directed.push_back(make_row(ROW_CFG, 0, 0, 0, 0, 0, 1, 1,
			0, 0, 0, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 1'b1, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			0, 0, 1, 0, 1'b1, KIND_FAIL));
		directed.push_back(make_row(ROW_CFG, 0, 0, 0, 0, 0, 511, 511,
			0, 0, 0, 0, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_SEARCH, 0, 0, 0, 0, 0, 0,
			254, 0, 255, 1, 1'b0, KIND_OK));
		directed.push_back(make_row(ROW_WORD, MODE_OBSTACLE, 3, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 1'b0, KIND_OK));

		foreach (directed[i]) begin
			if (directed[i].op == ROW_CFG) begin
				in_valid <= 1'b0;
				write_map(directed[i].ow, directed[i].oh);
			end else begin
				send_word(directed[i]);
			end
		end
		in_valid <= 1'b0;

		// Random phases: no idling, sender idle, receiver stall with hold-off, both
		run_phase(25, 0, 0, 6, 6, 1'b0, 1'b0);
		run_phase(25, 60, 0, 256, 256, 1'b1, 1'b0);
		run_phase(25, 0, 60, 5, 8, 1'b0, 1'b1);
		run_phase(25, 16, 16, 8, 4, 1'b0, 1'b0);

		drain();
		if (mismatches == 0) begin
			$display("grid_astar_path_search test passed");
		end else begin
			$display("grid_astar_path_search test failed");
		end
		$finish;
	end

	// Receiver: random ready, check each taken word against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind %0d (%0d,%0d)",
						kind, cell_x, cell_y));
				end else begin
					result_word_t e;
					e = expected_words.pop_front();
					if (kind !== e.kind)
						report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
					if (cell_x !== e.x)
						report_mismatch($sformatf("cell_x %0d, want %0d", cell_x, e.x));
					if (cell_y !== e.y)
						report_mismatch($sformatf("cell_y %0d, want %0d", cell_y, e.y));
					if (run_end !== e.last)
						report_mismatch($sformatf("run_end %0b, want %0b", run_end, e.last));
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("grid_astar_path_search test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
